// ----- design/framebuffer_pixel_to_rgb8_core_defines.svh -----
// Assertion macros for the framebuffer pixel converter.
// Expects clk and arst_n in the scope of each use.
`ifndef FRAMEBUFFER_PIXEL_TO_RGB8_CORE_DEFINES_SVH
`define FRAMEBUFFER_PIXEL_TO_RGB8_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FBRGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBRGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fbrgb_pkg.sv -----
// Shared types and codes for the framebuffer pixel to RGBA8 converter.
// No dependencies.
package fbrgb_pkg;

	typedef enum logic [1:0] {
		FMT_BGRA8   = 2'd0,
		FMT_RGBA8   = 2'd1,
		FMT_RGB10A2 = 2'd2,
		FMT_RGBA16F = 2'd3
	} fmt_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_ALPHA    = 2'd1;

	typedef struct packed {
		fmt_t source_format;
		logic keep_alpha;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

endpackage

// ----- design/framebuffer_pixel_to_rgb8_core.sv -----
// Framebuffer pixel to RGBA8 converter. Takes one pixel word per request and
// returns one result of 8-bit red, green, blue and alpha. A pixel goes through
// an input register, one pass of conversion logic and a result register, where
// its result is offered; one pixel can enter every clock while results are taken.
// While a finished result is held off downstream, one more pixel may enter the
// input register; after that the input stalls until the result is taken.
// Write source_format (index 0) and keep_alpha (index 1) only while no pixel is
// in flight; cfg_ready is always high.
`include "framebuffer_pixel_to_rgb8_core_defines.svh"

module framebuffer_pixel_to_rgb8_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fbrgb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbrgb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [63:0]                       pixel_word,
	output logic                              rgb_valid,
	input  logic                              rgb_stall,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	output logic [7:0]                        alpha
);

	fbrgb_pkg::cfg_t  cfg_q;
	logic             valid_s1;
	logic [63:0]      word_s1;
	logic             valid_s2;
	fbrgb_pkg::rgba_t rgba_s2;
	fbrgb_pkg::rgba_t rgba_next;
	logic             advance_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_format <= fbrgb_pkg::FMT_BGRA8;
			cfg_q.keep_alpha    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fbrgb_pkg::CFG_SOURCE_FORMAT) begin
				cfg_q.source_format <= fbrgb_pkg::fmt_t'(cfg_data[1:0]);
			end
			if (cfg_index == fbrgb_pkg::CFG_KEEP_ALPHA) begin
				cfg_q.keep_alpha <= cfg_data[0];
			end
		end
	end

	// result register moves when empty or taken; input register follows it
	assign advance_s2  = !valid_s2 || !rgb_stall;
	assign pixel_stall = valid_s1 && !advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pixel_stall) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pixel_stall && pixel_valid) begin
			word_s1 <= pixel_word;
		end
	end

	fbrgb_convert u_convert (
		.word(word_s1),
		.cfg (cfg_q),
		.rgba(rgba_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			rgba_s2 <= rgba_next;
		end
	end

	assign rgb_valid = valid_s2;
	assign red       = rgba_s2.red;
	assign green     = rgba_s2.green;
	assign blue      = rgba_s2.blue;
	assign alpha     = rgba_s2.alpha;

	`FBRGB_ASSERT_NEXT(a_s1_hold, valid_s1 && pixel_stall, valid_s1 && $stable(word_s1), "held pixel lost or changed")
	`FBRGB_ASSERT_NEXT(a_s1_to_s2, valid_s1 && advance_s2, valid_s2, "pixel dropped between stages")
	`FBRGB_ASSERT_NOW(a_alpha_off, valid_s2 && !cfg_q.keep_alpha, alpha == 8'h00, "alpha not cleared")
	`FBRGB_ASSERT_NEXT(a_half_nan, valid_s1 && advance_s2 && cfg_q.source_format == fbrgb_pkg::FMT_RGBA16F && word_s1[14:10] == 5'h1F && word_s1[9:0] != 10'd0, red == 8'h00, "half NaN not zeroed")

endmodule

// ----- design/fbrgb_unorm10.sv -----
// One 10-bit unorm channel to 8 bits, rounded: (c*255 + 511) / 1023.
// Standalone combinational logic, no package use.
module fbrgb_unorm10 (
	input  logic [9:0] chan,
	output logic [7:0] value
);

	localparam logic [10:0] UNORM10_MAX = 11'd1023;

	logic [17:0] scaled;
	logic [7:0]  quot_est;
	logic [10:0] rem_est;

	// x/1024 undershoots x/1023 by less than one, so one correction step suffices
	always_comb begin
		scaled   = {chan, 8'b0} - {8'b0, chan} + 18'd511;
		quot_est = scaled[17:10];
		rem_est  = {1'b0, scaled[9:0]} + {3'b0, quot_est};
		if (rem_est >= UNORM10_MAX) begin
			value = quot_est + 8'd1;
		end else begin
			value = quot_est;
		end
	end

endmodule

// ----- design/fbrgb_half8.sv -----
// One fp16 channel to 8 bits: NaN and negatives to 0, 1.0 and above to 255,
// otherwise floor(v*255 + 1/2) in exact integer form. No package use.
module fbrgb_half8 (
	input  logic [15:0] half,
	output logic [7:0]  value
);

	logic [4:0]  exp_v;
	logic [9:0]  frac_v;
	logic        is_nan;
	logic        is_neg;
	logic        is_big;
	logic [10:0] mant;
	logic [4:0]  exp_eff;
	logic [4:0]  shift_v;
	logic [19:0] prod;
	logic [24:0] bias;
	logic [24:0] sum;
	logic [24:0] shifted;
	logic [7:0]  rounded;

	always_comb begin
		exp_v   = half[14:10];
		frac_v  = half[9:0];
		is_nan  = (exp_v == 5'h1F) && (frac_v != 10'd0);
		is_neg  = half[15];
		is_big  = exp_v >= 5'd15;
		// subnormals share the scale of the smallest normal exponent
		if (exp_v == 5'd0) begin
			mant    = {1'b0, frac_v};
			exp_eff = 5'd1;
		end else begin
			mant    = {1'b1, frac_v};
			exp_eff = exp_v;
		end
		shift_v = 5'd25 - exp_eff;
		prod    = {1'b0, mant, 8'b0} - {9'b0, mant};
		bias    = 25'd1 << (shift_v - 5'd1);
		sum     = {5'b0, prod} + bias;
		shifted = sum >> shift_v;
		rounded = (shifted[24:8] != 17'd0) ? 8'hFF : shifted[7:0];
		priority if (is_nan || is_neg) begin
			value = 8'h00;
		end else if (is_big) begin
			value = 8'hFF;
		end else begin
			value = rounded;
		end
	end

endmodule

// ----- design/fbrgb_convert.sv -----
// Pixel word to RGBA8 for all four source layouts, selected by configuration.
// Uses fbrgb_pkg, fbrgb_unorm10 and fbrgb_half8.
module fbrgb_convert (
	input  logic [63:0]       word,
	input  fbrgb_pkg::cfg_t   cfg,
	output fbrgb_pkg::rgba_t  rgba
);

	logic [7:0] red10;
	logic [7:0] green10;
	logic [7:0] blue10;
	logic [7:0] red16;
	logic [7:0] green16;
	logic [7:0] blue16;
	logic [7:0] alpha16;

	fbrgb_unorm10 u_red10   (.chan(word[9:0]),   .value(red10));
	fbrgb_unorm10 u_green10 (.chan(word[19:10]), .value(green10));
	fbrgb_unorm10 u_blue10  (.chan(word[29:20]), .value(blue10));

	fbrgb_half8 u_red16   (.half(word[15:0]),  .value(red16));
	fbrgb_half8 u_green16 (.half(word[31:16]), .value(green16));
	fbrgb_half8 u_blue16  (.half(word[47:32]), .value(blue16));
	fbrgb_half8 u_alpha16 (.half(word[63:48]), .value(alpha16));

	always_comb begin
		unique case (cfg.source_format)
			fbrgb_pkg::FMT_BGRA8: begin
				rgba.red   = word[23:16];
				rgba.green = word[15:8];
				rgba.blue  = word[7:0];
				rgba.alpha = word[31:24];
			end
			fbrgb_pkg::FMT_RGBA8: begin
				rgba.red   = word[7:0];
				rgba.green = word[15:8];
				rgba.blue  = word[23:16];
				rgba.alpha = word[31:24];
			end
			fbrgb_pkg::FMT_RGB10A2: begin
				rgba.red   = red10;
				rgba.green = green10;
				rgba.blue  = blue10;
				// a*85 replicates the two alpha bits
				rgba.alpha = {4{word[31:30]}};
			end
			fbrgb_pkg::FMT_RGBA16F: begin
				rgba.red   = red16;
				rgba.green = green16;
				rgba.blue  = blue16;
				rgba.alpha = alpha16;
			end
			default: begin
				rgba = '0;
			end
		endcase
		// drop alpha on the RGB-only path
		if (!cfg.keep_alpha) begin
			rgba.alpha = 8'h00;
		end
	end

endmodule
